>>> design/omfd_pkg.sv
// shared types and constants for the object-file record deframer
package omfd_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	localparam logic [7:0] LIB_HEADER_TYPE = 8'hF0;
	localparam logic [7:0] MODEND_A_TYPE   = 8'h8A;
	localparam logic [7:0] MODEND_B_TYPE   = 8'h8B;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ZERO_LEN   = 3'd1,
		ST_BAD_CHKSUM = 3'd2,
		ST_TRUNCATED  = 3'd3,
		ST_DICTIONARY = 3'd4
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0]   out_byte;
		logic [7:0]   record_kind;
		logic [31:0]  record_start;
		logic [15:0]  payload_length;
		status_t      status;
		logic         library_flag;
		logic         last;
	} result_t;

endpackage

>>> design/omfd_stream_if.sv
// valid/ready channel interfaces for the byte stream and the results
interface omfd_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       end_of_stream;

	modport source (output valid, output stream_byte, output end_of_stream, input ready);
	modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface omfd_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  out_byte;
	logic [7:0]  record_kind;
	logic [31:0] record_start;
	logic [15:0] payload_length;
	logic [2:0]  status;
	logic        library_flag;
	logic        last;

	modport source (output valid, output result_kind, output out_byte, output record_kind,
		output record_start, output payload_length, output status, output library_flag,
		output last, input ready);
	modport sink (input valid, input result_kind, input out_byte, input record_kind,
		input record_start, input payload_length, input status, input library_flag,
		input last, output ready);
endinterface

>>> design/omfd_in_stage.sv
// input register for the byte stream
module omfd_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	omfd_stream_if.sink          stream,
	input  logic                 take,
	output logic                 valid_s1,
	output omfd_pkg::item_t      item_s1
);

	assign stream.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			item_s1.stream_byte   <= stream.stream_byte;
			item_s1.end_of_stream <= stream.end_of_stream;
		end
	end

endmodule

>>> design/omfd_parser.sv
// record parser: framing state, checksum, library header and padding skip
module omfd_parser #(
	parameter int OFFSET_BITS = omfd_pkg::OFFSET_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  omfd_pkg::item_t      item,
	output logic                 res_valid,
	output omfd_pkg::result_t    res
);

	typedef enum logic [6:0] {
		PH_TYPE  = 7'b0000001,
		PH_LENLO = 7'b0000010,
		PH_LENHI = 7'b0000100,
		PH_DATA  = 7'b0001000,
		PH_CHECK = 7'b0010000,
		PH_PAD   = 7'b0100000,
		PH_HALT  = 7'b1000000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [OFFSET_BITS-1:0] cur_start_q, cur_start_d;
	logic [7:0]             cur_type_q, cur_type_d;
	logic [7:0]             len_lo_q, len_lo_d;
	logic [15:0]            left_q, left_d;
	logic [15:0]            seen_q, seen_d;
	logic [7:0]             sum_q, sum_d;
	logic [16:0]            blk_len_q, blk_len_d;
	logic [16:0]            blk_pos_q, blk_pos_d;
	logic [31:0]            dict_q, dict_d;
	logic                   lib_q, lib_d;

	logic [7:0]             b;
	logic [7:0]             sum_b;
	logic [OFFSET_BITS-1:0] offset_adv;
	logic [16:0]            pos_inc;
	logic [16:0]            pos_adv;
	logic [63:0]            offset_ext;
	logic [63:0]            start_ext;
	logic                   header;
	logic [15:0]            len_full;
	logic [15:0]            plen_now;
	logic [16:0]            blk_len_new;
	logic [16:0]            pos_new;
	logic                   rv;
	omfd_pkg::result_t      r;

	assign b          = item.stream_byte;
	assign sum_b      = sum_q + b;
	assign offset_adv = offset_q + OFFSET_BITS'(1);
	assign pos_inc    = blk_pos_q + 17'd1;
	assign pos_adv    = (blk_len_q == 17'd0) ? blk_pos_q :
		((pos_inc >= blk_len_q) ? 17'd0 : pos_inc);
	assign offset_ext = 64'(offset_q);
	assign start_ext  = 64'(cur_start_q);
	assign header     = (cur_start_q == '0) && (cur_type_q == omfd_pkg::LIB_HEADER_TYPE);
	assign len_full   = {b, len_lo_q};
	assign plen_now   = seen_q + left_q;
	assign blk_len_new = header ? (17'(seen_q) + 17'd4) : blk_len_q;
	assign pos_new     = header ? 17'd0 : pos_adv;

	always_comb begin
		phase_d     = phase_q;
		offset_d    = offset_q;
		cur_start_d = cur_start_q;
		cur_type_d  = cur_type_q;
		len_lo_d    = len_lo_q;
		left_d      = left_q;
		seen_d      = seen_q;
		sum_d       = sum_q;
		blk_len_d   = blk_len_q;
		blk_pos_d   = blk_pos_q;
		dict_d      = dict_q;
		lib_d       = lib_q;
		rv          = 1'b0;

		r.result_kind    = omfd_pkg::KIND_STATUS;
		r.out_byte       = 8'd0;
		r.record_kind    = cur_type_q;
		r.record_start   = start_ext[31:0];
		r.payload_length = 16'd0;
		r.status         = omfd_pkg::ST_OK;
		r.library_flag   = 1'b0;
		r.last           = 1'b1;

		if (item.end_of_stream) begin
			if (phase_q == PH_LENLO || phase_q == PH_LENHI || phase_q == PH_DATA ||
					phase_q == PH_CHECK) begin
				rv       = 1'b1;
				r.status = omfd_pkg::ST_TRUNCATED;
				if (phase_q == PH_DATA || phase_q == PH_CHECK) begin
					r.payload_length = plen_now;
				end
			end
			phase_d     = PH_TYPE;
			offset_d    = '0;
			cur_start_d = '0;
			cur_type_d  = 8'd0;
			len_lo_d    = 8'd0;
			left_d      = 16'd0;
			seen_d      = 16'd0;
			sum_d       = 8'd0;
			blk_len_d   = 17'd0;
			blk_pos_d   = 17'd0;
			dict_d      = 32'd0;
			lib_d       = 1'b0;
		end else begin
			case (phase_q)
				PH_TYPE: begin
					if (dict_q != 32'd0 && offset_ext >= 64'(dict_q)) begin
						// dictionary reached, the byte is dropped
						phase_d        = PH_HALT;
						rv             = 1'b1;
						r.status       = omfd_pkg::ST_DICTIONARY;
						r.record_kind  = 8'd0;
						r.record_start = offset_ext[31:0];
					end else begin
						cur_type_d  = b;
						cur_start_d = offset_q;
						sum_d       = b;
						phase_d     = PH_LENLO;
						offset_d    = offset_adv;
						blk_pos_d   = pos_adv;
					end
				end
				PH_LENLO: begin
					len_lo_d  = b;
					sum_d     = sum_b;
					phase_d   = PH_LENHI;
					offset_d  = offset_adv;
					blk_pos_d = pos_adv;
				end
				PH_LENHI: begin
					sum_d     = sum_b;
					offset_d  = offset_adv;
					blk_pos_d = pos_adv;
					if (len_full == 16'd0) begin
						phase_d  = PH_HALT;
						rv       = 1'b1;
						r.status = omfd_pkg::ST_ZERO_LEN;
					end else begin
						left_d  = len_full - 16'd1;
						seen_d  = 16'd0;
						phase_d = (len_full != 16'd1) ? PH_DATA : PH_CHECK;
					end
				end
				PH_DATA: begin
					sum_d = sum_b;
					// first four data bytes of the library header give the dictionary offset
					if (header && seen_q < 16'd4) begin
						dict_d = dict_q | (32'(b) << {seen_q[1:0], 3'b000});
					end
					rv               = 1'b1;
					r.result_kind    = omfd_pkg::KIND_DATA;
					r.out_byte       = b;
					r.payload_length = plen_now;
					r.last           = 1'b0;
					seen_d           = seen_q + 16'd1;
					left_d           = left_q - 16'd1;
					if (left_q == 16'd1) begin
						phase_d = PH_CHECK;
					end
					offset_d  = offset_adv;
					blk_pos_d = pos_adv;
				end
				PH_CHECK: begin
					sum_d            = sum_b;
					offset_d         = offset_adv;
					blk_pos_d        = pos_adv;
					rv               = 1'b1;
					r.payload_length = seen_q;
					if (b != 8'd0 && sum_b != 8'd0) begin
						phase_d  = PH_HALT;
						r.status = omfd_pkg::ST_BAD_CHKSUM;
					end else begin
						if (header) begin
							blk_len_d = blk_len_new;
							blk_pos_d = 17'd0;
							if (seen_q < 16'd4) begin
								dict_d = 32'd0;
							end
							lib_d = ((blk_len_new & (blk_len_new - 17'd1)) == 17'd0);
						end
						if (blk_len_new != 17'd0 && pos_new != 17'd0 &&
								(cur_type_q == omfd_pkg::MODEND_A_TYPE ||
								cur_type_q == omfd_pkg::MODEND_B_TYPE)) begin
							phase_d = PH_PAD;
						end else begin
							phase_d = PH_TYPE;
						end
					end
				end
				PH_PAD: begin
					offset_d  = offset_adv;
					blk_pos_d = pos_adv;
					if (pos_adv == 17'd0) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
				end
			endcase
		end

		r.library_flag = item.end_of_stream ? lib_q : lib_d;
	end

	assign res_valid = rv;
	assign res       = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			offset_q    <= '0;
			cur_start_q <= '0;
			cur_type_q  <= 8'd0;
			len_lo_q    <= 8'd0;
			left_q      <= 16'd0;
			seen_q      <= 16'd0;
			sum_q       <= 8'd0;
			blk_len_q   <= 17'd0;
			blk_pos_q   <= 17'd0;
			dict_q      <= 32'd0;
			lib_q       <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			offset_q    <= offset_d;
			cur_start_q <= cur_start_d;
			cur_type_q  <= cur_type_d;
			len_lo_q    <= len_lo_d;
			left_q      <= left_d;
			seen_q      <= seen_d;
			sum_q       <= sum_d;
			blk_len_q   <= blk_len_d;
			blk_pos_q   <= blk_pos_d;
			dict_q      <= dict_d;
			lib_q       <= lib_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_pad_needs_block: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAD) |-> (blk_len_q != 17'd0))
		else $error("padding skip without a block length");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT && !item.end_of_stream) |-> !res_valid)
		else $error("result produced while halted");
`endif

endmodule

>>> design/omfd_out_stage.sv
// result register driving the result channel
module omfd_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  omfd_pkg::result_t    res,
	output logic                 free,
	omfd_result_if.source        result
);

	logic              valid_s2;
	omfd_pkg::result_t res_s2;

	assign free = !valid_s2 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res;
		end
	end

	assign result.valid          = valid_s2;
	assign result.result_kind    = res_s2.result_kind;
	assign result.out_byte       = res_s2.out_byte;
	assign result.record_kind    = res_s2.record_kind;
	assign result.record_start   = res_s2.record_start;
	assign result.payload_length = res_s2.payload_length;
	assign result.status         = res_s2.status;
	assign result.library_flag   = res_s2.library_flag;
	assign result.last           = res_s2.last;

endmodule

>>> design/omf_record_deframer_unit.sv
// top level of the object-file record deframer
// Takes an object-file byte stream, one byte per transfer, and splits it into records
// (type byte, little-endian length, data bytes, checksum byte). Every data byte comes out
// as a data result; the checksum byte gives one status result (ok or bad checksum), the
// high length byte reports a zero length; a library header at offset 0 sets the block size
// used to skip the padding after module end records and the dictionary offset at which
// parsing stops. A transfer with end_of_stream set carries no byte: it reports truncation
// if a record is open and returns the parser to its reset state. After any error the block
// swallows bytes until end of stream. Rate: one byte per clock cycle sustained while the
// result channel does not stall; a byte is held in the input register, then goes through
// the single-pass parser, and its result is registered in the result register. No
// clearing pass after reset.
module omf_record_deframer_unit #(
	parameter int OFFSET_BITS = omfd_pkg::OFFSET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	omfd_stream_if.sink   stream,
	omfd_result_if.source result
);

	logic              s1_valid;
	omfd_pkg::item_t   s1_item;
	logic              out_free;
	logic              fire;
	logic              res_valid;
	omfd_pkg::result_t res;

	// an item moves into the parser whenever the result register can take its result
	assign fire = s1_valid && out_free;

	omfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.take     (fire),
		.valid_s1 (s1_valid),
		.item_s1  (s1_item)
	);

	// all framing state lives here and updates once per consumed item
	omfd_parser #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (s1_item),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register, parts the result side from the stream side
	omfd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_valid),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.last == result.result_kind))
		else $error("last does not match result kind");
	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.result_kind) |-> (result.status == omfd_pkg::ST_OK))
		else $error("data result with nonzero status");
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> (s1_valid && !out_free))
		else $error("stream stalled without a held item");
	a_held_item_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !fire) |=> s1_valid)
		else $error("held item lost");
`endif

endmodule

>>> tb/sv/tb_omf_record_deframer_unit.sv
// self-checking testbench for the object-file record deframer top level
`timescale 1ns / 100ps

module tb_omf_record_deframer_unit;
	import omfd_pkg::*;

	// how the expected result of a stimulus row is found
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_RESULT,
		TYPED
	} check_how_t;

	typedef struct {
		logic       eos;
		logic [7:0] b;
		check_how_t how;
		result_t    want;
	} stim_row_t;

	// parser phases of the predictor, in stream order
	typedef enum logic [2:0] {
		WANT_TYPE,
		WANT_LEN_LO,
		WANT_LEN_HI,
		IN_DATA,
		WANT_CHECK,
		IN_PADDING,
		STOPPED
	} parse_phase_t;

	localparam int DIR_ROWS   = 27;
	localparam int RAND_ITEMS = 1800;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	omfd_stream_if byte_if ();
	omfd_result_if rec_if ();

	omf_record_deframer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_if),
		.result (rec_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// directed stimulus: library header, module end with padding, bad checksum,
	// zero length, and a maximum-length record cut short by end of stream
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{1'b1, 8'h00, NO_RESULT, '0},
		// empty library header at offset 0: block length 4, no dictionary
		'{1'b0, 8'hF0, NO_RESULT, '0},
		'{1'b0, 8'h01, NO_RESULT, '0},
		'{1'b0, 8'h00, NO_RESULT, '0},
		'{1'b0, 8'h0F, TYPED,
			'{KIND_STATUS, 8'h00, 8'hF0, 32'd0, 16'd0, ST_OK, 1'b1, 1'b1}},
		// module end with one data byte, ends off the block boundary
		'{1'b0, 8'h8A, NO_RESULT, '0},
		'{1'b0, 8'h02, NO_RESULT, '0},
		'{1'b0, 8'h00, NO_RESULT, '0},
		'{1'b0, 8'h5A, TYPED,
			'{KIND_DATA, 8'h5A, 8'h8A, 32'd4, 16'd1, ST_OK, 1'b1, 1'b0}},
		'{1'b0, 8'h1A, TYPED,
			'{KIND_STATUS, 8'h00, 8'h8A, 32'd4, 16'd1, ST_OK, 1'b1, 1'b1}},
		// padding up to offset 12
		'{1'b0, 8'hFF, BY_MODEL, '0},
		'{1'b0, 8'h00, BY_MODEL, '0},
		'{1'b0, 8'hAA, BY_MODEL, '0},
		// empty record with a wrong checksum, then halted until end of stream
		'{1'b0, 8'h90, BY_MODEL, '0},
		'{1'b0, 8'h01, BY_MODEL, '0},
		'{1'b0, 8'h00, BY_MODEL, '0},
		'{1'b0, 8'h01, TYPED,
			'{KIND_STATUS, 8'h00, 8'h90, 32'd12, 16'd0, ST_BAD_CHKSUM, 1'b1, 1'b1}},
		'{1'b1, 8'h00, NO_RESULT, '0},
		// zero length is reported at the high length byte
		'{1'b0, 8'h96, NO_RESULT, '0},
		'{1'b0, 8'h00, NO_RESULT, '0},
		'{1'b0, 8'h00, TYPED,
			'{KIND_STATUS, 8'h00, 8'h96, 32'd0, 16'd0, ST_ZERO_LEN, 1'b0, 1'b1}},
		'{1'b1, 8'h00, NO_RESULT, '0},
		// longest record, truncated after one data byte
		'{1'b0, 8'hFF, NO_RESULT, '0},
		'{1'b0, 8'hFF, NO_RESULT, '0},
		'{1'b0, 8'hFF, NO_RESULT, '0},
		'{1'b0, 8'h00, TYPED,
			'{KIND_DATA, 8'h00, 8'hFF, 32'd0, 16'd65534, ST_OK, 1'b0, 1'b0}},
		'{1'b1, 8'h00, TYPED,
			'{KIND_STATUS, 8'h00, 8'hFF, 32'd0, 16'd65534, ST_TRUNCATED, 1'b0, 1'b1}}
	};

	stim_row_t   rows [$];
	result_t     deframed_q [$];
	int unsigned drive_idx  = 0;
	int unsigned acc_idx    = 0;
	int unsigned cycles     = 0;
	int unsigned cycle_limit = 32'hFFFF_FFFF;
	int unsigned fail_count = 0;
	bit          calm       = 1'b0;

	// predictor state
	parse_phase_t ph;
	logic [31:0]  byte_offs;
	logic [7:0]   rec_type;
	logic [31:0]  rec_start;
	logic [7:0]   len_low_b;
	logic [15:0]  data_left;
	logic [15:0]  data_seen;
	logic [7:0]   sum_acc;
	logic [16:0]  blk_len;
	logic [16:0]  blk_pos;
	logic [31:0]  dict_at;
	logic         lib_seen;

	task automatic clear_parser();
		ph        = WANT_TYPE;
		byte_offs = '0;
		rec_type  = '0;
		rec_start = '0;
		len_low_b = '0;
		data_left = '0;
		data_seen = '0;
		sum_acc   = '0;
		blk_len   = '0;
		blk_pos   = '0;
		dict_at   = '0;
		lib_seen  = 1'b0;
	endtask

	// one byte further: the block position wraps at the block length
	task automatic step_offset();
		byte_offs = byte_offs + 32'd1;
		if (blk_len != 0) begin
			blk_pos = blk_pos + 17'd1;
			if (blk_pos >= blk_len)
				blk_pos = '0;
		end
	endtask

	function automatic result_t status_item(logic [7:0] kind, logic [31:0] start,
		logic [15:0] plen, status_t st);
		result_t r;
		r                = '0;
		r.result_kind    = KIND_STATUS;
		r.record_kind    = kind;
		r.record_start   = start;
		r.payload_length = plen;
		r.status         = st;
		r.library_flag   = lib_seen;
		r.last           = 1'b1;
		return r;
	endfunction

	// predicts the result, if any, of one accepted transfer
	task automatic deframe_byte(input logic [7:0] b, input logic eos, output bit has,
		output result_t r);
		logic [15:0] len;
		has = 1'b0;
		r   = '0;
		if (eos) begin
			// an open record is reported as truncated, then everything clears
			if (ph >= WANT_LEN_LO && ph <= WANT_CHECK) begin
				len = (ph >= IN_DATA) ? data_seen + data_left : 16'd0;
				r   = status_item(rec_type, rec_start, len, ST_TRUNCATED);
				has = 1'b1;
			end
			clear_parser();
			return;
		end
		case (ph)
			WANT_TYPE: begin
				if (dict_at != 0 && byte_offs >= dict_at) begin
					// dictionary reached: byte dropped, parsing stops
					ph  = STOPPED;
					r   = status_item(8'h00, byte_offs, 16'd0, ST_DICTIONARY);
					has = 1'b1;
				end else begin
					rec_type  = b;
					rec_start = byte_offs;
					sum_acc   = b;
					ph        = WANT_LEN_LO;
					step_offset();
				end
			end
			WANT_LEN_LO: begin
				len_low_b = b;
				sum_acc   = sum_acc + b;
				ph        = WANT_LEN_HI;
				step_offset();
			end
			WANT_LEN_HI: begin
				len     = {b, len_low_b};
				sum_acc = sum_acc + b;
				step_offset();
				if (len == 0) begin
					ph  = STOPPED;
					r   = status_item(rec_type, rec_start, 16'd0, ST_ZERO_LEN);
					has = 1'b1;
				end else begin
					data_left = len - 16'd1;
					data_seen = '0;
					ph        = (data_left != 0) ? IN_DATA : WANT_CHECK;
				end
			end
			IN_DATA: begin
				sum_acc = sum_acc + b;
				// first four bytes of the library header hold the dictionary offset
				if (rec_start == 0 && rec_type == LIB_HEADER_TYPE && data_seen < 4)
					dict_at = dict_at | ({24'h0, b} << (8 * data_seen));
				r                = '0;
				r.result_kind    = KIND_DATA;
				r.out_byte       = b;
				r.record_kind    = rec_type;
				r.record_start   = rec_start;
				r.payload_length = data_seen + data_left;
				r.status         = ST_OK;
				r.library_flag   = lib_seen;
				has              = 1'b1;
				data_seen        = data_seen + 16'd1;
				data_left        = data_left - 16'd1;
				if (data_left == 0)
					ph = WANT_CHECK;
				step_offset();
			end
			WANT_CHECK: begin
				sum_acc = sum_acc + b;
				step_offset();
				has = 1'b1;
				if (b != 0 && sum_acc != 0) begin
					ph = STOPPED;
					r  = status_item(rec_type, rec_start, data_seen, ST_BAD_CHKSUM);
				end else begin
					if (rec_start == 0 && rec_type == LIB_HEADER_TYPE) begin
						blk_len = {1'b0, data_seen} + 17'd4;
						blk_pos = '0;
						if (data_seen < 4)
							dict_at = '0;
						lib_seen = ((blk_len & (blk_len - 17'd1)) == 0);
					end
					if (blk_len != 0 && blk_pos != 0
						&& (rec_type == MODEND_A_TYPE || rec_type == MODEND_B_TYPE))
						ph = IN_PADDING;
					else
						ph = WANT_TYPE;
					r = status_item(rec_type, rec_start, data_seen, ST_OK);
				end
			end
			IN_PADDING: begin
				step_offset();
				if (blk_pos == 0)
					ph = WANT_TYPE;
			end
			default: begin
			end
		endcase
	endtask

	task automatic append_item(logic eos, logic [7:0] b);
		stim_row_t row;
		row.eos  = eos;
		row.b    = b;
		row.how  = BY_MODEL;
		row.want = '0;
		rows.push_back(row);
	endtask

	// one random file: optional library header, records with module ends and
	// padding, sometimes noise, a broken checksum or an early end of stream
	task automatic build_object_file();
		logic [7:0]  f [$];
		logic [7:0]  t;
		logic [7:0]  d;
		logic [7:0]  c;
		logic [7:0]  rsum;
		logic [31:0] dict;
		int          style;
		int          hdr_n;
		int          blk;
		int          cnt;
		int          dlen;
		int          r;
		int          k;
		style = $urandom_range(0, 9);
		blk   = 0;
		hdr_n = -1;
		if (style == 0) begin
			cnt = $urandom_range(1, 24);
			repeat (cnt) f.push_back(8'($urandom));
		end else begin
			if (style <= 5) begin
				case ($urandom_range(0, 3))
					0: hdr_n = 4;
					1: hdr_n = 12;
					2: hdr_n = 0;
					default: hdr_n = $urandom_range(0, 14);
				endcase
				f.push_back(LIB_HEADER_TYPE);
				f.push_back(8'(hdr_n + 1));
				f.push_back(8'h00);
				repeat (hdr_n) f.push_back(8'($urandom));
				f.push_back(8'h00);
				blk = hdr_n + 4;
			end
			cnt = $urandom_range(1, 8);
			repeat (cnt) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					t = (r < 15) ? MODEND_A_TYPE : MODEND_B_TYPE;
				else
					t = 8'($urandom);
				r = $urandom_range(0, 99);
				if (r < 4)
					dlen = -1;
				else if (r < 92)
					dlen = $urandom_range(0, 6);
				else
					dlen = $urandom_range(7, 60);
				f.push_back(t);
				if (dlen < 0) begin
					f.push_back(8'h00);
					f.push_back(8'h00);
				end else begin
					f.push_back(8'(dlen + 1));
					f.push_back(8'((dlen + 1) >> 8));
					rsum = t + 8'(dlen + 1) + 8'((dlen + 1) >> 8);
					repeat (dlen) begin
						d    = 8'($urandom);
						rsum = rsum + d;
						f.push_back(d);
					end
					r = $urandom_range(0, 99);
					if (r < 80)
						c = 8'h00 - rsum;
					else if (r < 90)
						c = 8'h00;
					else
						c = 8'($urandom);
					f.push_back(c);
					// skip to the next block boundary after a good module end
					if (blk != 0 && (t == MODEND_A_TYPE || t == MODEND_B_TYPE)
						&& (c == 0 || 8'(rsum + c) == 0))
						repeat ((blk - f.size() % blk) % blk) f.push_back(8'($urandom));
				end
			end
			if (hdr_n >= 4) begin
				r = $urandom_range(0, 2);
				if (r == 0)
					dict = '0;
				else if (r == 1)
					dict = $urandom_range(1, f.size() + 4);
				else
					dict = $urandom;
				for (int i = 0; i < 4; i++)
					f[3 + i] = 8'(dict >> (8 * i));
			end
			if (hdr_n >= 0) begin
				rsum = '0;
				for (int i = 0; i < hdr_n + 3; i++)
					rsum = rsum + f[i];
				f[hdr_n + 3] = ($urandom_range(0, 9) != 0) ? 8'h00 - rsum : 8'($urandom);
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, f.size());
			while (f.size() > k)
				f.delete(f.size() - 1);
		end
		foreach (f[i])
			append_item(1'b0, f[i]);
		append_item(1'b1, 8'($urandom));
	endtask

	// mostly short gaps, a few long ones, none while calm
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// byte source: holds each transfer until accepted, random gaps between them
	initial begin
		int unsigned gap_left;
		gap_left              = 0;
		byte_if.valid         = 1'b0;
		byte_if.stream_byte   = 8'h00;
		byte_if.end_of_stream = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!byte_if.valid || byte_if.ready) begin
				if (gap_left != 0) begin
					byte_if.valid <= 1'b0;
					gap_left--;
				end else if (drive_idx < rows.size()) begin
					byte_if.valid         <= 1'b1;
					byte_if.stream_byte   <= rows[drive_idx].b;
					byte_if.end_of_stream <= rows[drive_idx].eos;
					drive_idx++;
					gap_left = pick_gap();
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// result sink: random stretches of back-pressure
	initial begin
		int unsigned stall_left;
		stall_left   = 0;
		rec_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				rec_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rec_if.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// predict on every byte transfer, check every result transfer in order
	always @(posedge clk) begin : monitor
		stim_row_t row;
		result_t   pred;
		result_t   want;
		bit        has;
		cycles++;
		if ($urandom_range(0, 199) == 0)
			calm <= !calm;
		if (arst_n && byte_if.valid && byte_if.ready) begin
			row = rows[acc_idx];
			acc_idx++;
			deframe_byte(byte_if.stream_byte, byte_if.end_of_stream, has, pred);
			case (row.how)
				BY_MODEL: begin
					if (has)
						deframed_q.push_back(pred);
				end
				TYPED: begin
					deframed_q.push_back(row.want);
				end
				default: begin
				end
			endcase
		end
		if (arst_n && rec_if.valid && rec_if.ready) begin
			if (deframed_q.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = deframed_q.pop_front();
				check_field("result_kind", 32'(rec_if.result_kind), 32'(want.result_kind));
				check_field("out_byte", 32'(rec_if.out_byte), 32'(want.out_byte));
				check_field("record_kind", 32'(rec_if.record_kind), 32'(want.record_kind));
				check_field("record_start", rec_if.record_start, want.record_start);
				check_field("payload_length", 32'(rec_if.payload_length),
					32'(want.payload_length));
				check_field("status", 32'(rec_if.status), 32'(want.status));
				check_field("library_flag", 32'(rec_if.library_flag),
					32'(want.library_flag));
				check_field("last", 32'(rec_if.last), 32'(want.last));
			end
		end
	end

	// watchdog on a stuck handshake
	initial begin
		@(posedge clk);
		while (cycles <= cycle_limit)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		clear_parser();
		foreach (directed_rows[i])
			rows.push_back(directed_rows[i]);
		while (rows.size() < DIR_ROWS + RAND_ITEMS)
			build_object_file();
		// worst case per byte: longest gap, longest stall, the pipeline registers
		cycle_limit = rows.size() * 300 + 10000;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (acc_idx < rows.size() || deframed_q.size() != 0)
			@(posedge clk);
		// wait past the pipeline depth to catch stray results
		repeat (24) @(posedge clk);
		// a stray result may still be held back by a stall
		if (rec_if.valid)
			report_mismatch("result left over at the end");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
